// ===== sv/bss_pkg.sv =====
// Shared types and codes for the bounded stack with search and sort.
// Used by the front, queue and back modules, the top level and the port checker.
// No dependencies.
package bss_pkg;

    localparam int ACT_W   = 3;
    localparam int DATA_W  = 32;
    localparam int ST_W    = 2;
    localparam int POS_W   = 3;
    localparam int MATCH_W = 4;
    localparam int FILL_W  = 4;

    // Action codes as they arrive on the input stream
    localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DISPLAY = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UPDATE  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SORT    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_COUNT   = 3'd6;

    // Command kinds after classification; every unused action folds into CMD_COUNT
    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_POP     = 3'd1;
    localparam logic [2:0] CMD_DISPLAY = 3'd2;
    localparam logic [2:0] CMD_SEARCH  = 3'd3;
    localparam logic [2:0] CMD_UPDATE  = 3'd4;
    localparam logic [2:0] CMD_SORT    = 3'd5;
    localparam logic [2:0] CMD_COUNT   = 3'd6;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] repl;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [DATA_W-1:0]  data;
        logic [POS_W-1:0]   pos;
        logic [MATCH_W-1:0] match_cnt;
        logic [FILL_W-1:0]  depth;
        logic               last;
    } t_result;

endpackage

// ===== sv/bss_front.sv =====
// Front stage: accepts input transactions and classifies the action into a command.
// Depends on bss_pkg.
module bss_front
    import bss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [DATA_W-1:0] i_key,
    input  logic [DATA_W-1:0] i_repl,
    output logic              o_valid,
    input  logic              i_ready,
    output t_cmd              o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.key  = i_key;
        n_cmd.repl = i_repl;
        unique case (i_action)
            ACT_PUSH:    n_cmd.kind = CMD_PUSH;
            ACT_POP:     n_cmd.kind = CMD_POP;
            ACT_DISPLAY: n_cmd.kind = CMD_DISPLAY;
            ACT_SEARCH:  n_cmd.kind = CMD_SEARCH;
            ACT_UPDATE:  n_cmd.kind = CMD_UPDATE;
            ACT_SORT:    n_cmd.kind = CMD_SORT;
            default:     n_cmd.kind = CMD_COUNT;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== sv/bss_queue.sv =====
// Two-entry command queue between the front and back stages.
// Depends on bss_pkg.
module bss_queue
    import bss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] Q_FULL = 2'd2;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    assign o_ready = (r_count != Q_FULL);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign wr_en   = i_valid && o_ready;
    assign rd_en   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/bss_back.sv =====
// Back stage: holds the entry registers and fill count, runs each command and
// drives the registered result. Depends on bss_pkg.
module bss_back
    import bss_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int IW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_SORT = 2'd2;

    logic [1:0]        r_state,  n_state;
    logic [CW-1:0]     r_fill,   n_fill;
    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] n_mem [STACK_DEPTH];
    logic [2:0]        r_kind,   n_kind;
    logic [DATA_W-1:0] r_key,    n_key;
    logic [DATA_W-1:0] r_repl,   n_repl;
    logic [IW-1:0]     r_idx,    n_idx;
    logic [CW-1:0]     r_cnt,    n_cnt;
    logic [IW-1:0]     r_first,  n_first;
    logic [CW-1:0]     r_pass,   n_pass;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_res;
    logic              n_emit;

    logic              out_free;
    logic [IW-1:0]     top_idx;
    logic [IW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              walk_match;
    logic              walk_last;
    logic [CW-1:0]     walk_total;
    logic [IW-1:0]     walk_first;

    assign out_free   = !r_out_valid || i_ready;
    assign top_idx    = IW'(r_fill - 1'b1);
    assign rd_addr    = (r_state == S_IDLE) ? top_idx : r_idx;
    assign rd_data    = r_mem[rd_addr];
    assign walk_match = (rd_data == r_key);
    assign walk_last  = (CW'(r_idx) == (r_fill - 1'b1));
    assign walk_total = r_cnt + CW'(walk_match);
    assign walk_first = (r_cnt == '0) ? r_idx : r_first;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_mem   = r_mem;
        n_kind  = r_kind;
        n_key   = r_key;
        n_repl  = r_repl;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_pass  = r_pass;
        n_emit  = 1'b0;
        n_res   = '0;
        o_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = out_free;
                if (i_valid && out_free) begin
                    n_kind      = i_cmd.kind;
                    n_key       = i_cmd.key;
                    n_repl      = i_cmd.repl;
                    n_idx       = '0;
                    n_cnt       = '0;
                    n_first     = '0;
                    n_pass      = '0;
                    n_emit      = 1'b1;
                    n_res.last  = 1'b1;
                    n_res.depth = FILL_W'(r_fill);
                    if (i_cmd.kind == CMD_PUSH) begin
                        if (r_fill >= FULL_COUNT) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_mem[r_fill[IW-1:0]] = i_cmd.key;
                            n_fill      = r_fill + 1'b1;
                            n_res.depth = FILL_W'(r_fill + 1'b1);
                        end
                    end else if (i_cmd.kind == CMD_COUNT) begin
                        n_res.status = ST_OK;
                    end else if (r_fill == '0) begin
                        n_res.status = ST_EMPTY;
                    end else begin
                        unique case (i_cmd.kind)
                            CMD_POP: begin
                                n_fill      = r_fill - 1'b1;
                                n_res.data  = rd_data;
                                n_res.depth = FILL_W'(r_fill - 1'b1);
                            end
                            CMD_DISPLAY, CMD_SEARCH, CMD_UPDATE: begin
                                n_emit  = 1'b0;
                                n_state = S_WALK;
                            end
                            CMD_SORT: begin
                                n_emit  = 1'b0;
                                n_state = S_SORT;
                            end
                            default: begin
                                n_res.status = ST_OK;
                            end
                        endcase
                    end
                end
            end
            S_WALK: begin
                if (out_free) begin
                    n_idx = r_idx + 1'b1;
                    if (r_kind == CMD_DISPLAY) begin
                        n_emit      = 1'b1;
                        n_res.data  = rd_data;
                        n_res.pos   = POS_W'(r_idx);
                        n_res.depth = FILL_W'(r_fill);
                        n_res.last  = walk_last;
                    end else begin
                        n_cnt   = walk_total;
                        n_first = walk_first;
                        if (walk_match && (r_kind == CMD_UPDATE)) begin
                            n_mem[r_idx] = r_repl;
                        end
                        if (walk_last) begin
                            n_emit      = 1'b1;
                            n_res.last  = 1'b1;
                            n_res.depth = FILL_W'(r_fill);
                            if (walk_total == '0) begin
                                n_res.status = ST_NOT_FOUND;
                            end else begin
                                n_res.pos       = POS_W'(walk_first);
                                n_res.match_cnt = MATCH_W'(walk_total);
                            end
                        end
                    end
                    if (walk_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SORT: begin
                if (r_pass == r_fill) begin
                    if (out_free) begin
                        n_emit      = 1'b1;
                        n_res.last  = 1'b1;
                        n_res.depth = FILL_W'(r_fill);
                        n_state     = S_IDLE;
                    end
                end else begin
                    // One odd-even transposition pass: disjoint neighbor pairs
                    for (int j = 0; j < STACK_DEPTH - 1; j++) begin
                        if ((1'(j) == r_pass[0]) && (CW'(j + 1) < r_fill) &&
                            ($signed(r_mem[j]) > $signed(r_mem[j + 1]))) begin
                            n_mem[j]     = r_mem[j + 1];
                            n_mem[j + 1] = r_mem[j];
                        end
                    end
                    n_pass = r_pass + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem   <= n_mem;
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_repl  <= n_repl;
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
        r_first <= n_first;
        r_pass  <= n_pass;
        if (n_emit) begin
            r_out <= n_res;
        end
    end

endmodule

// ===== sv/bounded_stack_search_sort.sv =====
// Top level of the bounded stack with search, update, display and sort.
// Depends on bss_pkg, bss_front, bss_queue and bss_back.
//
// Fixed-depth stack of STACK_DEPTH signed 32-bit words on a pair of streams. Each
// input transaction carries one action in tuser (0 push, 1 pop, 2 display, 3 search,
// 4 update, 5 sort, 6 count; code 7 acts as count) and its operands in tdata. Every
// action returns one result transaction, except display, which returns one per held
// entry from bottom to top; tlast marks the final result of each action. A front
// register classifies the action and a two-entry queue decouples it from the back
// stage, so new transactions are accepted while the back stage works or while a
// result waits on the output register, until the queue and front register fill.
// The back stage sets the rate and takes no new action until the current one is
// done: push, pop, count and the full and empty cases report on acceptance; display,
// search and update walk the held entries in turn, since the back stage reads the
// entry registers through a single read port; sort runs one odd-even transposition
// pass per held entry and then reports. An action passes through the front register
// and a queue slot before it reaches the back stage. Output backpressure stalls the
// back stage, but sort passes go on and only the sort report waits. Entries need
// no clearing after reset: only entries below the fill count are ever read.
module bounded_stack_search_sort
    import bss_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // [31:0] operand_value, [63:32] replacement_value
    input  logic [2:0]  i_s_axis_tuser,  // [2:0] action
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // [31:0] data_word, [34:32] position,
                                         // [38:35] match_total, [42:39] depth_used,
                                         // [47:43] zero
    output logic [1:0]  o_m_axis_tuser,  // [1:0] status
    output logic        o_m_axis_tlast   // last_result
);

    logic    front_valid;
    logic    front_ready;
    t_cmd    front_cmd;
    logic    queue_valid;
    logic    queue_ready;
    t_cmd    queue_cmd;
    t_result result;

    // Accept and classify the action
    bss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_action (i_s_axis_tuser),
        .i_key    (i_s_axis_tdata[31:0]),
        .i_repl   (i_s_axis_tdata[63:32]),
        .o_valid  (front_valid),
        .i_ready  (front_ready),
        .o_cmd    (front_cmd)
    );

    // Hold up to two classified commands while the back stage is busy
    bss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_cmd   (queue_cmd)
    );

    // Execute against the entry registers and drive the result register
    bss_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .o_ready  (queue_ready),
        .i_cmd    (queue_cmd),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    // Pack the result fields onto the output stream
    assign o_m_axis_tdata = {5'd0, result.depth, result.match_cnt, result.pos, result.data};
    assign o_m_axis_tuser = result.status;
    assign o_m_axis_tlast = result.last;

endmodule

// ===== sv/bss_checker.sv =====
// Port-level checker for the bounded stack, attached to the top level by bind.
// Depends on bss_pkg and bounded_stack_search_sort.
module bss_checker
    import bss_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // Hold a stalled result unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
         $stable(o_m_axis_tlast)))
        else $error("result changed while stalled");

    // Error results always end their transaction group
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_OK)) |-> o_m_axis_tlast)
        else $error("error result not marked last");

    // Empty status reports no entries and no data
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY)) |->
        ((o_m_axis_tdata[42:39] == 4'd0) && (o_m_axis_tdata[31:0] == 32'd0)))
        else $error("empty result with nonzero depth or data");

    // Results before the last one are display rows with OK status and no match information
    a_display_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |->
        ((o_m_axis_tuser == ST_OK) && (o_m_axis_tdata[38:35] == 4'd0)))
        else $error("intermediate result with bad status or match count");

    // Key not found reports no position, no matches and no data
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_NOT_FOUND)) |->
        ((o_m_axis_tdata[38:32] == 7'd0) && (o_m_axis_tdata[31:0] == 32'd0)))
        else $error("not-found result with position, matches or data");

endmodule

bind bounded_stack_search_sort bss_checker u_bss_checker (.*);
